// ===== rtl/lge_pkg.sv =====
// Package for the life generation engine: operation codes, controller states,
// sweep phases and the command and status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lge_pkg;

	localparam int OP_W = 2;
	localparam int CELL_BITS = 8;
	localparam int IN_DATA_W = 24;
	localparam int OUT_DATA_W = 8;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_STEP  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_CLEAR,
		ST_STEP,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		PH_MID,
		PH_UP,
		PH_DOWN
	} phase_t;

	typedef struct packed {
		logic capture;
		logic host_wr;
		logic host_rd;
		logic clr_wr;
		logic step_rd;
		logic flip;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic rd_last;
		logic busy;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/lge_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lge_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lge_ctrl.sv =====
// Controller of the life generation engine: sequences reset clearing, host byte
// access, grid clear and generation sweeps. Depends on lge_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lge_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [lge_pkg::OP_W-1:0]      s_tuser,
	input  wire lge_pkg::status_t              status,
	output lge_pkg::cmd_t                      cmd
);

	import lge_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cmd.clr_wr = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					unique case (op_t'(s_tuser))
						OP_WRITE: state_d = ST_WRITE;
						OP_READ:  state_d = ST_READ;
						OP_STEP:  state_d = ST_STEP;
						OP_CLEAR: state_d = ST_CLEAR;
					endcase
				end
			end
			ST_WRITE: begin
				cmd.host_wr = 1'b1;
				state_d = ST_FINISH;
			end
			ST_READ: begin
				cmd.host_rd = 1'b1;
				state_d = ST_FINISH;
			end
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (status.clr_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_STEP: begin
				cmd.step_rd = 1'b1;
				if (status.rd_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.busy) begin
					cmd.flip = 1'b1;
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/lge_dp.sv =====
// Datapath of the life generation engine: grid RAM with two banks, sweep counters,
// three-column neighbor window, Life rule and output register. Depends on lge_pkg, lge_ram.
`timescale 1ns / 1ps
`default_nettype none

module lge_dp #(
	parameter int GRID_WIDTH  = 128,
	parameter int GRID_HEIGHT = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire lge_pkg::cmd_t                     cmd,
	output lge_pkg::status_t                       status,
	input  wire logic [lge_pkg::IN_DATA_W-1:0]     s_tdata,
	input  wire logic [lge_pkg::OP_W-1:0]          s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [lge_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic      [lge_pkg::OP_W-1:0]          m_tuser
);

	import lge_pkg::*;

	localparam int PAGE_COUNT = (GRID_HEIGHT + 7) / 8;
	localparam int CELLS      = GRID_WIDTH * PAGE_COUNT;
	localparam int IDXW       = $clog2(CELLS);
	localparam int AW         = IDXW + 1;
	localparam int PGW        = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int CW         = $clog2(GRID_WIDTH);
	localparam int KW         = $clog2(GRID_WIDTH + 2);
	localparam int LAST_BIT   = (GRID_HEIGHT - 1) % 8;
	localparam int LAST_ROWS  = GRID_HEIGHT - 8 * (PAGE_COUNT - 1);
	localparam int VW         = CELL_BITS + 2;

	// captured item
	op_t                  op_q;
	logic [6:0]           column_q;
	logic [2:0]           page_q;
	logic [CELL_BITS-1:0] write_data_q;

	// control state
	logic                 bank_q;
	logic [IDXW-1:0]      clr_cnt_q;
	logic [PGW-1:0]       spage_q;
	logic [KW-1:0]        k_q;
	phase_t               ph_q;
	logic                 vld_s1;
	logic                 vld_s2;
	logic                 m_tvalid_q;

	// pipeline payload
	phase_t               ph_s1;
	logic [KW-1:0]        k_s1;
	logic [PGW-1:0]       page_s1;
	logic [IDXW-1:0]      widx_s2;
	logic                 last_s2;
	logic [CELL_BITS-1:0] mid_hold_q;
	logic [CELL_BITS-1:0] up_hold_q;
	logic [VW-1:0]        left_q;
	logic [VW-1:0]        mid_q;
	logic [VW-1:0]        right_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [OP_W-1:0]      m_tuser_q;

	logic                 in_range;
	logic [IDXW-1:0]      host_idx;
	logic [CW-1:0]        col_rd;
	logic [PGW-1:0]       page_rd;
	logic [IDXW-1:0]      step_idx;
	logic                 page_top;
	logic                 page_last;
	logic                 k_last;
	logic [VW-1:0]        col_vec;
	logic [CELL_BITS-1:0] new_byte;

	logic                 ram_wr_en;
	logic [AW-1:0]        ram_wr_addr;
	logic [CELL_BITS-1:0] ram_wr_data;
	logic                 ram_rd_en;
	logic [AW-1:0]        ram_rd_addr;
	logic [CELL_BITS-1:0] ram_rd_data;

	assign in_range = (9'(column_q) < 9'(GRID_WIDTH)) && (6'(page_q) < 6'(PAGE_COUNT));
	assign host_idx = IDXW'(page_q) * IDXW'(GRID_WIDTH) + IDXW'(column_q);

	assign k_last    = (k_q == KW'(GRID_WIDTH + 1));
	assign page_top  = (spage_q == '0);
	assign page_last = (spage_q == PGW'(PAGE_COUNT - 1));

	always_comb begin
		if (k_q == '0) begin
			col_rd = CW'(GRID_WIDTH - 1);
		end else if (k_last) begin
			col_rd = '0;
		end else begin
			col_rd = CW'(k_q - KW'(1));
		end
		unique case (ph_q)
			PH_MID:  page_rd = spage_q;
			PH_UP:   page_rd = page_top ? PGW'(PAGE_COUNT - 1) : PGW'(spage_q - PGW'(1));
			PH_DOWN: page_rd = page_last ? '0 : PGW'(spage_q + PGW'(1));
			default: page_rd = spage_q;
		endcase
	end

	assign step_idx = IDXW'(page_rd) * IDXW'(GRID_WIDTH) + IDXW'(col_rd);

	assign status.clr_last = (clr_cnt_q == IDXW'(CELLS - 1));
	assign status.rd_last  = (ph_q == PH_DOWN) && k_last && page_last;
	assign status.busy     = vld_s1 || vld_s2;
	assign status.out_free = !m_tvalid_q || m_tready;

	// sweep counters and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q     <= 1'b0;
			clr_cnt_q  <= '0;
			spage_q    <= '0;
			k_q        <= '0;
			ph_q       <= PH_MID;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				clr_cnt_q <= status.clr_last ? '0 : IDXW'(clr_cnt_q + IDXW'(1));
			end
			if (cmd.step_rd) begin
				if (ph_q == PH_DOWN) begin
					ph_q <= PH_MID;
					if (k_last) begin
						k_q <= '0;
						spage_q <= page_last ? '0 : PGW'(spage_q + PGW'(1));
					end else begin
						k_q <= KW'(k_q + KW'(1));
					end
				end else if (ph_q == PH_MID) begin
					ph_q <= PH_UP;
				end else begin
					ph_q <= PH_DOWN;
				end
			end
			if (cmd.flip) begin
				bank_q <= !bank_q;
			end
			vld_s1 <= cmd.step_rd;
			vld_s2 <= vld_s1 && (ph_s1 == PH_DOWN) && (k_s1 >= KW'(2));
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// column vector: slot 0 is the row above the page, slots 1..8 the page, slot 9 below
	always_comb begin
		col_vec = '0;
		col_vec[0] = (page_s1 == '0) ? up_hold_q[LAST_BIT] : up_hold_q[CELL_BITS-1];
		for (int b = 0; b < CELL_BITS; b++) begin
			if ((page_s1 != PGW'(PAGE_COUNT - 1)) || (b < LAST_ROWS)) begin
				col_vec[b+1] = mid_hold_q[b];
			end else if (b == LAST_ROWS) begin
				col_vec[b+1] = ram_rd_data[0];
			end else begin
				col_vec[b+1] = 1'b0;
			end
		end
		if ((page_s1 != PGW'(PAGE_COUNT - 1)) || (LAST_ROWS == CELL_BITS)) begin
			col_vec[VW-1] = ram_rd_data[0];
		end
	end

	// Life rule over the window
	always_comb begin
		logic [3:0] cnt;
		new_byte = '0;
		for (int b = 0; b < CELL_BITS; b++) begin
			cnt = 4'(left_q[b]) + 4'(left_q[b+1]) + 4'(left_q[b+2])
				+ 4'(mid_q[b]) + 4'(mid_q[b+2])
				+ 4'(right_q[b]) + 4'(right_q[b+1]) + 4'(right_q[b+2]);
			if (!last_s2 || (b < LAST_ROWS)) begin
				new_byte[b] = (cnt == 4'd3) || (mid_q[b+1] && (cnt == 4'd2));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q         <= op_t'(s_tuser);
			column_q     <= s_tdata[6:0];
			page_q       <= s_tdata[9:7];
			write_data_q <= s_tdata[17:10];
		end
		if (cmd.step_rd) begin
			ph_s1   <= ph_q;
			k_s1    <= k_q;
			page_s1 <= spage_q;
		end
		if (vld_s1) begin
			unique case (ph_s1)
				PH_MID: mid_hold_q <= ram_rd_data;
				PH_UP:  up_hold_q  <= ram_rd_data;
				PH_DOWN: begin
					left_q  <= mid_q;
					mid_q   <= right_q;
					right_q <= col_vec;
					widx_s2 <= IDXW'(page_s1) * IDXW'(GRID_WIDTH) + IDXW'(CW'(k_s1 - KW'(2)));
					last_s2 <= (page_s1 == PGW'(PAGE_COUNT - 1));
				end
				default: mid_hold_q <= mid_hold_q;
			endcase
		end
		if (cmd.load_out) begin
			m_tuser_q <= op_q;
			m_tdata_q <= ((op_q == OP_READ) && in_range) ? ram_rd_data : '0;
		end
	end

	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = {bank_q, host_idx};
		ram_wr_data = write_data_q;
		if (vld_s2) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = {!bank_q, widx_s2};
			ram_wr_data = new_byte;
		end else if (cmd.clr_wr) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = {bank_q, clr_cnt_q};
			ram_wr_data = '0;
		end else if (cmd.host_wr && in_range) begin
			ram_wr_en   = 1'b1;
		end
	end

	assign ram_rd_en   = cmd.host_rd || cmd.step_rd;
	assign ram_rd_addr = cmd.step_rd ? {bank_q, step_idx} : {bank_q, host_idx};

	lge_ram #(
		.WIDTH (CELL_BITS),
		.DEPTH (2 ** AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

// ===== rtl/life_generation_engine.sv =====
// Top level of the life generation engine: toroidal B3/S23 Life grid stored as
// display pages. Depends on lge_pkg, lge_ctrl, lge_dp (with lge_ram).
//
// Usage:
//   Slave channel s_*: one item per operation. s_tuser holds the operation
//   (write byte, read byte, advance one generation, clear grid); s_tdata holds
//   column, page and write_data. Master channel m_*: exactly one item per
//   accepted item, carrying the read byte (zero unless a read within the grid)
//   and the echoed operation.
//   Sequence: write and read go from acceptance through capture and RAM access to
//   the output register; clear writes zeros to every cell of the active bank; a
//   generation reads three pages per column through the single RAM read port and
//   writes the new bytes to the other bank. One item is worked on at a time.
//   Reset: a clearing pass over the active bank of GRID_WIDTH*pages cells (1024
//   at 128 x 64) runs first and s_tready stays low meanwhile.
//   Stall: a finished result sits in the output register; the next item is
//   accepted while it waits, and its own result holds until m_tready frees it.
`timescale 1ns / 1ps
`default_nettype none

module life_generation_engine #(
	parameter int GRID_WIDTH  = 128,
	parameter int GRID_HEIGHT = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // column[6:0], page[9:7], write_data[17:10]
	input  wire logic [1:0]  s_tuser,   // operation[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [7:0]  m_tdata,   // read_data[7:0]
	output logic      [1:0]  m_tuser    // completed_operation[1:0]
);

	import lge_pkg::*;

	cmd_t    cmd;
	status_t status;

	lge_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.status   (status),
		.cmd      (cmd)
	);

	lge_dp #(
		.GRID_WIDTH  (GRID_WIDTH),
		.GRID_HEIGHT (GRID_HEIGHT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire
